FILE: rtl/core/swept_aabb_collision_time_defines.svh
// Shared assertion macros for the swept box collision block.
`ifndef SWEPT_AABB_COLLISION_TIME_DEFINES_SVH
`define SWEPT_AABB_COLLISION_TIME_DEFINES_SVH

// Check an implication that holds on every edge outside reset.
`define SAC_ASSERT_IMP(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("swept box collision check failed");

// Check an implication whose consequent holds in the cycle after the antecedent.
`define SAC_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("swept box collision check failed one cycle on");

`endif

FILE: rtl/core/sac_pkg.sv
package sac_pkg;

	localparam int CW       = 24;            // coordinate width
	localparam int NW       = CW + 1;        // difference width
	localparam int FB       = 16;            // time fraction bits
	localparam int QB       = 8 + FB + 1;    // quotient magnitude bits
	localparam int RW       = NW + FB;       // scaled numerator width
	localparam int TW       = CW + QB;       // trial divisor width
	localparam int RATIO_W  = 8 + FB + 3;    // signed ratio width, holds +/-INF
	localparam int DIV_LAT  = QB + 2;        // divider register stages
	localparam int ET_W     = FB + 1;

	localparam logic signed [RATIO_W-1:0] ONE_T = RATIO_W'(1) <<< FB;
	localparam logic signed [RATIO_W-1:0] SAT_T = RATIO_W'(1) <<< (FB + 8);
	localparam logic signed [RATIO_W-1:0] INF_T = RATIO_W'(1) <<< (FB + 9);

	typedef struct packed {
		logic early_miss;
		logic dx_zero;
		logic dy_zero;
		logic dx_pos;
		logic dy_pos;
	} ctrl_t;

	typedef struct packed {
		ctrl_t                 ctrl;
		logic signed [NW-1:0]  xe_num;
		logic signed [NW-1:0]  xx_num;
		logic signed [NW-1:0]  ye_num;
		logic signed [NW-1:0]  yx_num;
		logic signed [CW-1:0]  dx_den;
		logic signed [CW-1:0]  dy_den;
	} front_t;

endpackage

FILE: rtl/core/sac_front.sv
module sac_front (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [sac_pkg::CW-1:0] mov_left,
	input  logic signed [sac_pkg::CW-1:0] mov_top,
	input  logic signed [sac_pkg::CW-1:0] mov_right,
	input  logic signed [sac_pkg::CW-1:0] mov_bottom,
	input  logic signed [sac_pkg::CW-1:0] move_dx,
	input  logic signed [sac_pkg::CW-1:0] move_dy,
	input  logic signed [sac_pkg::CW-1:0] stat_left,
	input  logic signed [sac_pkg::CW-1:0] stat_top,
	input  logic signed [sac_pkg::CW-1:0] stat_right,
	input  logic signed [sac_pkg::CW-1:0] stat_bottom,
	output sac_pkg::front_t              front_s1
);

	logic signed [sac_pkg::NW-1:0] ml, mt, mr, mb, dx, dy, sl, st, sr, sb;
	logic signed [sac_pkg::NW-1:0] bl, bt, br, bb;
	logic dx_pos, dy_pos, dx_zero, dy_zero, apart;
	sac_pkg::front_t front_d;

	always_comb begin
		ml = sac_pkg::NW'(mov_left);
		mt = sac_pkg::NW'(mov_top);
		mr = sac_pkg::NW'(mov_right);
		mb = sac_pkg::NW'(mov_bottom);
		dx = sac_pkg::NW'(move_dx);
		dy = sac_pkg::NW'(move_dy);
		sl = sac_pkg::NW'(stat_left);
		st = sac_pkg::NW'(stat_top);
		sr = sac_pkg::NW'(stat_right);
		sb = sac_pkg::NW'(stat_bottom);
		dx_pos  = !move_dx[sac_pkg::CW-1] && (move_dx != '0);
		dy_pos  = !move_dy[sac_pkg::CW-1] && (move_dy != '0);
		dx_zero = (move_dx == '0);
		dy_zero = (move_dy == '0);
		bl = dx_pos ? ml : ml + dx;
		bt = dy_pos ? mt : mt + dy;
		br = dx_pos ? mr + dx : mr;
		bb = dy_pos ? mb + dy : mb;
		apart = (br < sl) || (bl > sr) || (bb < st) || (bt > sb);
		front_d.ctrl.early_miss = apart || (dx_zero && dy_zero);
		front_d.ctrl.dx_zero    = dx_zero;
		front_d.ctrl.dy_zero    = dy_zero;
		front_d.ctrl.dx_pos     = dx_pos;
		front_d.ctrl.dy_pos     = dy_pos;
		front_d.xe_num = dx_pos ? sl - mr : sr - ml;
		front_d.xx_num = dx_pos ? sr - ml : sl - mr;
		front_d.ye_num = dy_pos ? st - mb : sb - mt;
		front_d.yx_num = dy_pos ? sb - mt : st - mb;
		// zero motion axis is overridden later; keep the divisor nonzero
		front_d.dx_den = dx_zero ? sac_pkg::CW'(1) : move_dx;
		front_d.dy_den = dy_zero ? sac_pkg::CW'(1) : move_dy;
	end

	always_ff @(posedge clk) begin
		if (en) front_s1 <= front_d;
	end

endmodule

FILE: rtl/core/sac_div.sv
// Floor of (num * 2^FB) / den, saturated, one quotient bit per stage.
module sac_div (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [sac_pkg::NW-1:0]     num,
	input  logic signed [sac_pkg::CW-1:0]     den,
	output logic signed [sac_pkg::RATIO_W-1:0] ratio_s
);

	localparam int QB = sac_pkg::QB;
	localparam int RW = sac_pkg::RW;
	localparam int TW = sac_pkg::TW;
	localparam int CW = sac_pkg::CW;
	localparam int NW = sac_pkg::NW;
	localparam int RTW = sac_pkg::RATIO_W;

	logic [RW-1:0] rem_s [0:QB];
	logic [QB-1:0] quo_s [0:QB];
	logic [CW-1:0] dvs_s [0:QB];
	logic          neg_s [0:QB];
	logic          ovf_s [0:QB];

	logic [NW-1:0] n_abs;
	logic [CW-1:0] d_abs;
	logic          p_ovf, p_neg;

	always_comb begin
		n_abs = num[NW-1] ? NW'(-num) : NW'(num);
		d_abs = den[CW-1] ? CW'(-den) : CW'(den);
		p_ovf = TW'({n_abs, {sac_pkg::FB{1'b0}}}) >= (TW'(d_abs) << QB);
		p_neg = (num[NW-1] ^ den[CW-1]) && (num != '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {n_abs, {sac_pkg::FB{1'b0}}};
			quo_s[0] <= '0;
			dvs_s[0] <= d_abs;
			neg_s[0] <= p_neg;
			ovf_s[0] <= p_ovf;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_stage
		localparam int BIT = QB - 1 - k;
		logic [TW-1:0] trial;
		logic          take;
		always_comb begin
			trial = TW'(dvs_s[k]) << BIT;
			take  = TW'(rem_s[k]) >= trial;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? RW'(TW'(rem_s[k]) - trial) : rem_s[k];
				quo_s[k+1] <= quo_s[k] | (take ? (QB'(1) << BIT) : '0);
				dvs_s[k+1] <= dvs_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	logic [QB:0]    mag_f;
	logic [RTW-1:0] mag_c;

	always_comb begin
		mag_f = {1'b0, quo_s[QB]} + ((neg_s[QB] && (rem_s[QB] != '0)) ? (QB+1)'(1) : '0);
		if (ovf_s[QB] || (RTW'(mag_f) > RTW'(sac_pkg::SAT_T))) mag_c = sac_pkg::SAT_T;
		else mag_c = RTW'(mag_f);
	end

	always_ff @(posedge clk) begin
		if (en) ratio_s <= neg_s[QB] ? -$signed(mag_c) : $signed(mag_c);
	end

endmodule

FILE: rtl/core/sac_resolve.sv
module sac_resolve (
	input  sac_pkg::ctrl_t                     ctrl,
	input  logic signed [sac_pkg::RATIO_W-1:0] rxe,
	input  logic signed [sac_pkg::RATIO_W-1:0] rxx,
	input  logic signed [sac_pkg::RATIO_W-1:0] rye,
	input  logic signed [sac_pkg::RATIO_W-1:0] ryx,
	output logic                               hit,
	output logic [sac_pkg::ET_W-1:0]           entry_time,
	output logic signed [1:0]                  normal_x,
	output logic signed [1:0]                  normal_y
);

	logic signed [sac_pkg::RATIO_W-1:0] txe, txx, tye, tyx, te, tx;
	logic x_face;

	always_comb begin
		txe = ctrl.dx_zero ? -sac_pkg::INF_T : rxe;
		txx = ctrl.dx_zero ?  sac_pkg::INF_T : rxx;
		tye = ctrl.dy_zero ? -sac_pkg::INF_T : rye;
		tyx = ctrl.dy_zero ?  sac_pkg::INF_T : ryx;
		x_face = txe > tye;
		te = x_face ? txe : tye;
		tx = (txx < tyx) ? txx : tyx;
		hit = !(ctrl.early_miss || (txe[sac_pkg::RATIO_W-1] && tye[sac_pkg::RATIO_W-1])
			|| (txe > sac_pkg::ONE_T) || (tye > sac_pkg::ONE_T) || (te > tx));
		entry_time = hit ? te[sac_pkg::ET_W-1:0] : '0;
		normal_x = (hit && x_face) ? (ctrl.dx_pos ? 2'sb11 : 2'sb01) : 2'sb00;
		normal_y = (hit && !x_face) ? (ctrl.dy_pos ? 2'sb11 : 2'sb01) : 2'sb00;
	end

endmodule

FILE: rtl/core/swept_aabb_collision_time.sv
// Swept box collision time: one box pair per cycle in while s_tready is high, one
// result per pair out, in order. The result word passes through the input
// register, the divider prep register, the 25-stage restoring dividers (one
// quotient bit each), the divider saturation register and the output register
// before it appears on m_tdata. The whole pipeline advances together; while
// the output word is held, s_tready is low and nothing moves.
module swept_aabb_collision_time (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// mov_left, mov_top, mov_right, mov_bottom, move_dx, move_dy,
	// stat_left, stat_top, stat_right, stat_bottom (24 bits each)
	input  logic [239:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// hit, entry_time[16:0], normal_x[1:0], normal_y[1:0], zero pad
	output logic [23:0]  m_tdata
);

	localparam int CW = sac_pkg::CW;
	localparam int DL = sac_pkg::DIV_LAT;

	logic            adv;
	logic            vld_s1;
	logic            vld_d [0:DL-1];
	sac_pkg::ctrl_t  ctrl_d [0:DL-1];
	sac_pkg::front_t front_s1;
	logic signed [sac_pkg::RATIO_W-1:0] rxe, rxx, rye, ryx;
	logic                       hit;
	logic [sac_pkg::ET_W-1:0]   entry_time;
	logic signed [1:0]          normal_x, normal_y;
	logic                       m_tvalid_q;
	logic [23:0]                m_tdata_q;

	// advance everything unless the output word is stuck
	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = adv;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	sac_front u_front (
		.clk         (clk),
		.en          (adv),
		.mov_left    (s_tdata[0*CW +: CW]),
		.mov_top     (s_tdata[1*CW +: CW]),
		.mov_right   (s_tdata[2*CW +: CW]),
		.mov_bottom  (s_tdata[3*CW +: CW]),
		.move_dx     (s_tdata[4*CW +: CW]),
		.move_dy     (s_tdata[5*CW +: CW]),
		.stat_left   (s_tdata[6*CW +: CW]),
		.stat_top    (s_tdata[7*CW +: CW]),
		.stat_right  (s_tdata[8*CW +: CW]),
		.stat_bottom (s_tdata[9*CW +: CW]),
		.front_s1    (front_s1)
	);

	sac_div u_div_xe (.clk(clk), .en(adv), .num(front_s1.xe_num), .den(front_s1.dx_den),
		.ratio_s(rxe));
	sac_div u_div_xx (.clk(clk), .en(adv), .num(front_s1.xx_num), .den(front_s1.dx_den),
		.ratio_s(rxx));
	sac_div u_div_ye (.clk(clk), .en(adv), .num(front_s1.ye_num), .den(front_s1.dy_den),
		.ratio_s(rye));
	sac_div u_div_yx (.clk(clk), .en(adv), .num(front_s1.yx_num), .den(front_s1.dy_den),
		.ratio_s(ryx));

	sac_resolve u_resolve (
		.ctrl       (ctrl_d[DL-1]),
		.rxe        (rxe),
		.rxx        (rxx),
		.rye        (rye),
		.ryx        (ryx),
		.hit        (hit),
		.entry_time (entry_time),
		.normal_x   (normal_x),
		.normal_y   (normal_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < DL; i++) vld_d[i] <= 1'b0;
		end else if (adv) begin
			vld_s1     <= s_tvalid;
			vld_d[0]   <= vld_s1;
			for (int i = 1; i < DL; i++) vld_d[i] <= vld_d[i-1];
			m_tvalid_q <= vld_d[DL-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctrl_d[0] <= front_s1.ctrl;
			for (int i = 1; i < DL; i++) ctrl_d[i] <= ctrl_d[i-1];
			m_tdata_q <= {2'b00, normal_y, normal_x, entry_time, hit};
		end
	end

endmodule

FILE: rtl/core/sac_checker.sv
`include "swept_aabb_collision_time_defines.svh"

module sac_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [239:0] s_tdata,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [23:0]  m_tdata
);

	logic unused_in;
	assign unused_in = s_tvalid ^ (^s_tdata);

	`SAC_ASSERT_IMP(a_miss_clean, clk, arst_n, m_tvalid && !m_tdata[0], m_tdata[23:1] == '0)
	`SAC_ASSERT_IMP(a_one_face, clk, arst_n, m_tvalid && m_tdata[0],
		(m_tdata[19:18] == 2'b00) != (m_tdata[21:20] == 2'b00))
	`SAC_ASSERT_IMP(a_time_range, clk, arst_n, m_tvalid, m_tdata[17:1] <= 17'd65536)
	`SAC_ASSERT_IMP(a_ready_when_empty, clk, arst_n, !m_tvalid, s_tready)
	`SAC_ASSERT_NEXT(a_hold_out, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata))

endmodule

bind swept_aabb_collision_time sac_checker u_sac_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
